// ===== rtl/core/ad_input_multiplexer_assert.svh =====
// Assertion macros used by the checker module of the A/D multiplexer
`ifndef AD_INPUT_MULTIPLEXER_ASSERT_SVH
`define AD_INPUT_MULTIPLEXER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define ADIM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define ADIM_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/adim_pkg.sv =====
// Shared types and constants of the A/D input multiplexer
package adim_pkg;

    localparam int ADIM_CHANNELS = 128;
    localparam int CH_W          = 7;
    localparam int WORD_W        = 36;
    localparam int SAMPLE_W      = 12;
    localparam int RATE_W        = 8;
    localparam int LEVEL_W       = 3;
    localparam int AXIS_W        = 16;

    localparam logic [SAMPLE_W-1:0] SAMPLE_RESET = 12'd1000;
    localparam logic [RATE_W-1:0]   MIN_PERIOD   = 8'd10;

    typedef enum logic [2:0] {
        CMD_CTRL_WR   = 3'd0,
        CMD_STATUS_RD = 3'd1,
        CMD_START_WR  = 3'd2,
        CMD_DATA_RD   = 3'd3,
        CMD_TICK      = 3'd4,
        CMD_LOAD      = 3'd5
    } cmd_t;

    // Write request into the channel store
    typedef struct packed {
        logic                en;
        logic [CH_W-1:0]     addr;
        logic [SAMPLE_W-1:0] data;
    } chw_req_t;

endpackage

// ===== rtl/core/adim_chan_store.sv =====
// Channel value store: synchronous memory with valid bits and write forwarding
module adim_chan_store
    import adim_pkg::*;
#(
    parameter int CHANNELS = ADIM_CHANNELS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [CH_W-1:0]     rd_addr,
    input  chw_req_t            wr,
    output logic [SAMPLE_W-1:0] rd_value
);

    localparam int AW = $clog2(CHANNELS);

    logic [SAMPLE_W-1:0] chan_mem [CHANNELS];
    logic [CHANNELS-1:0] vld_reg;
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                rd_vld_reg;
    logic                rd_rng_reg;
    logic                hit_reg;
    logic [SAMPLE_W-1:0] hit_data_reg;
    logic                wr_ok;
    logic                rd_ok;

    assign wr_ok = wr.en && ({1'b0, wr.addr} < (CH_W+1)'(CHANNELS));
    assign rd_ok = {1'b0, rd_addr} < (CH_W+1)'(CHANNELS);

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            chan_mem[wr.addr[AW-1:0]] <= wr.data;
        end
        if (rd_ok) begin
            rd_data_reg <= chan_mem[rd_addr[AW-1:0]];
        end
        hit_data_reg <= wr.data;
    end

    // Track written entries and capture read-side control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            rd_rng_reg <= 1'b1;
            hit_reg    <= 1'b0;
        end else begin
            if (wr_ok) begin
                vld_reg[wr.addr[AW-1:0]] <= 1'b1;
            end
            rd_vld_reg <= rd_ok && vld_reg[rd_addr[AW-1:0]];
            rd_rng_reg <= rd_ok;
            hit_reg    <= wr_ok && (wr.addr == rd_addr);
        end
    end

    // Forward a same-cycle write; out-of-range reads give zero, unwritten entries the reset value
    always_comb begin
        if (!rd_rng_reg) begin
            rd_value = '0;
        end else if (hit_reg) begin
            rd_value = hit_data_reg;
        end else if (rd_vld_reg) begin
            rd_value = rd_data_reg;
        end else begin
            rd_value = SAMPLE_RESET;
        end
    end

endmodule

// ===== rtl/core/ad_input_multiplexer.sv =====
// Top level of the A/D input multiplexer with its command decoder and output register
//
// The block takes one command beat per clock while unstalled and returns one
// result beat per command, in the cycle after acceptance, from an output register;
// s_ready stays high while that register is empty or being drained by m_ready, so
// sustained rate is one beat per cycle. Channel values sit in a CHANNELS x 12
// synchronous memory whose read port prefetches the current channel every cycle;
// a load to that channel in the same cycle is forwarded. Per-entry valid bits make
// unwritten channels read as 1000 out of reset, so no clearing pass is needed.
module ad_input_multiplexer
    import adim_pkg::*;
#(
    parameter int CHANNELS = ADIM_CHANNELS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [LEVEL_W-1:0]       cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2:0]               s_command,
    input  logic [WORD_W-1:0]        s_bus_data,
    input  logic [CH_W-1:0]          s_channel_index,
    input  logic signed [AXIS_W-1:0] s_axis_value,
    input  logic                     s_negate,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [WORD_W-1:0]        m_read_data,
    output logic                     m_irq_request,
    output logic [LEVEL_W-1:0]       m_irq_pia,
    output logic [LEVEL_W-1:0]       m_irq_mpx_level,
    output logic                     m_done_res
);

    logic [LEVEL_W-1:0]  mpx_reg;
    logic [LEVEL_W-1:0]  pia_reg, pia_next;
    logic                pack_reg, pack_next;
    logic                seq_reg, seq_next;
    logic [RATE_W-1:0]   rate_reg, rate_next;
    logic                done_reg, done_next;
    logic [WORD_W-1:0]   word_reg, word_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic [CH_W-1:0]     start_reg, start_next;
    logic [CH_W-1:0]     cc_reg, cc_next;
    logic [RATE_W-1:0]   cd_reg, cd_next;
    logic                armed_reg, armed_next;
    logic                irq_reg, irq_next;

    logic                m_valid_reg;
    logic [WORD_W-1:0]   rdata_reg, rdata_next;
    logic                o_irq_reg;
    logic [LEVEL_W-1:0]  o_pia_reg, o_mpx_reg;
    logic                o_done_reg;

    logic                accept;
    logic [SAMPLE_W-1:0] sample;
    chw_req_t            wr_req;
    logic [RATE_W-1:0]   new_rate;
    logic [RATE_W-1:0]   period_cur;
    logic [RATE_W-1:0]   period_new;
    logic [RATE_W-1:0]   cd_dec;
    logic [1:0]          limit;
    logic [1:0]          cnt_inc;
    logic [CH_W-1:0]     cc_inc;
    logic [CH_W-1:0]     cc_step;
    logic [AXIS_W-1:0]   biased;
    logic [AXIS_W-1:0]   conv;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;

    // Period with its floor, for the current and a newly written rate
    assign new_rate   = s_bus_data[16:9];
    assign period_cur = (rate_reg < MIN_PERIOD) ? MIN_PERIOD : rate_reg;
    assign period_new = (new_rate < MIN_PERIOD) ? MIN_PERIOD : new_rate;
    assign cd_dec     = (cd_reg != '0) ? cd_reg - 1'b1 : cd_reg;
    assign limit      = pack_reg ? 2'd3 : 2'd1;
    assign cnt_inc    = cnt_reg + 1'b1;

    // Sequence step wraps past the last channel
    assign cc_inc  = cc_reg + 1'b1;
    assign cc_step = ({1'b0, cc_inc} < (CH_W+1)'(CHANNELS)) ? cc_inc : '0;

    // Load conversion: bias, optional inversion, drop five bits
    assign biased = {~s_axis_value[AXIS_W-1], s_axis_value[AXIS_W-2:0]};
    assign conv   = s_negate ? ~biased : biased;

    // Command decode and state update
    always_comb begin
        pia_next   = pia_reg;
        pack_next  = pack_reg;
        seq_next   = seq_reg;
        rate_next  = rate_reg;
        done_next  = done_reg;
        word_next  = word_reg;
        cnt_next   = cnt_reg;
        start_next = start_reg;
        cc_next    = cc_reg;
        cd_next    = cd_reg;
        armed_next = armed_reg;
        irq_next   = irq_reg;
        rdata_next = '0;
        wr_req.en   = 1'b0;
        wr_req.addr = s_channel_index;
        wr_req.data = {1'b0, conv[AXIS_W-1:5]};
        if (accept) begin
            case (cmd_t'(s_command))
                CMD_CTRL_WR: begin
                    pia_next   = s_bus_data[2:0];
                    pack_next  = s_bus_data[5];
                    seq_next   = s_bus_data[6];
                    rate_next  = new_rate;
                    done_next  = 1'b0;
                    word_next  = '0;
                    cnt_next   = '0;
                    cc_next    = start_reg;
                    irq_next   = 1'b0;
                    cd_next    = period_new;
                    armed_next = 1'b1;
                end
                CMD_STATUS_RD: begin
                    rdata_next = {1'b1, 28'd0, seq_reg, pack_reg, 1'b0, done_reg, pia_reg};
                end
                CMD_START_WR: begin
                    start_next = s_bus_data[CH_W-1:0];
                end
                CMD_DATA_RD: begin
                    rdata_next = word_reg;
                    word_next  = '0;
                    cnt_next   = '0;
                    done_next  = 1'b0;
                    irq_next   = 1'b0;
                    cd_next    = period_cur;
                    armed_next = 1'b1;
                end
                CMD_TICK: begin
                    if (armed_reg) begin
                        cd_next = cd_dec;
                        if (cd_dec == '0) begin
                            if (cnt_reg < limit) begin
                                word_next = {word_reg[WORD_W-SAMPLE_W-1:0], sample};
                                cnt_next  = cnt_inc;
                                cc_next   = seq_reg ? cc_step : start_reg;
                            end
                            if (cnt_next == limit) begin
                                done_next = 1'b1;
                                if (pia_reg != '0) begin
                                    irq_next = 1'b1;
                                end
                            end
                            // Re-arm unless the word is complete
                            if (done_next) begin
                                armed_next = 1'b0;
                                cd_next    = '0;
                            end else begin
                                armed_next = 1'b1;
                                cd_next    = period_cur;
                            end
                        end
                    end
                end
                CMD_LOAD: begin
                    wr_req.en = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    adim_chan_store #(
        .CHANNELS (CHANNELS)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_addr  (cc_next),
        .wr       (wr_req),
        .rd_value (sample)
    );

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mpx_reg   <= '0;
            pia_reg   <= '0;
            pack_reg  <= 1'b0;
            seq_reg   <= 1'b0;
            rate_reg  <= '0;
            done_reg  <= 1'b0;
            word_reg  <= '0;
            cnt_reg   <= '0;
            start_reg <= '0;
            cc_reg    <= '0;
            cd_reg    <= '0;
            armed_reg <= 1'b0;
            irq_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mpx_reg <= cfg_wr_data;
            end
            pia_reg   <= pia_next;
            pack_reg  <= pack_next;
            seq_reg   <= seq_next;
            rate_reg  <= rate_next;
            done_reg  <= done_next;
            word_reg  <= word_next;
            cnt_reg   <= cnt_next;
            start_reg <= start_next;
            cc_reg    <= cc_next;
            cd_reg    <= cd_next;
            armed_reg <= armed_next;
            irq_reg   <= irq_next;
        end
    end

    // Output beat valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= accept;
        end
    end

    // Output beat payload: hold until taken
    always_ff @(posedge aclk) begin
        if (accept) begin
            rdata_reg  <= rdata_next;
            o_irq_reg  <= irq_next;
            o_pia_reg  <= irq_next ? pia_next : '0;
            o_mpx_reg  <= irq_next ? mpx_reg : '0;
            o_done_reg <= done_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_read_data     = rdata_reg;
    assign m_irq_request   = o_irq_reg;
    assign m_irq_pia       = o_pia_reg;
    assign m_irq_mpx_level = o_mpx_reg;
    assign m_done_res      = o_done_reg;

endmodule

// ===== rtl/core/adim_checker.sv =====
// Port-level checker for the A/D input multiplexer, bound to the top level
`include "ad_input_multiplexer_assert.svh"

module adim_checker
    import adim_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic [2:0]          s_command,
    input logic                m_valid,
    input logic                m_ready,
    input logic [WORD_W-1:0]   m_read_data,
    input logic                m_irq_request,
    input logic [LEVEL_W-1:0]  m_irq_pia,
    input logic [LEVEL_W-1:0]  m_irq_mpx_level,
    input logic                m_done_res
);

    logic              s_beat;
    logic              stat_beat;
    logic              quiet_beat;
    logic              out_noreq;
    logic              out_req;
    logic              lvl_zero;
    logic              stat_ok;
    logic              data_zero;
    logic              out_stall;
    logic [WORD_W:0]   out_beat;

    assign s_beat     = s_valid && s_ready;
    assign stat_beat  = s_beat && (s_command == CMD_STATUS_RD);
    assign quiet_beat = s_beat && (s_command == CMD_TICK || s_command == CMD_LOAD ||
                                   s_command == CMD_START_WR);
    assign out_noreq  = m_valid && !m_irq_request;
    assign out_req    = m_valid && m_irq_request;
    assign lvl_zero   = (m_irq_pia == '0) && (m_irq_mpx_level == '0);
    assign stat_ok    = m_valid && m_read_data[WORD_W-1];
    assign data_zero  = m_valid && (m_read_data == '0);
    assign out_stall  = m_valid && !m_ready;
    assign out_beat   = {m_valid, m_read_data};

    // Levels are only reported alongside a request
    `ADIM_ASSERT_NOW(a_irq_levels, aclk, aresetn, out_noreq, lvl_zero, "levels without request")

    // A request only stands while the sample word is complete
    `ADIM_ASSERT_NOW(a_irq_done, aclk, aresetn, out_req, m_done_res, "irq request without done")

    // A status read always returns the assigned bit in the next beat
    `ADIM_ASSERT_NXT(a_status_bit, aclk, aresetn, stat_beat, stat_ok, "status lacks assigned bit")

    // Tick, load and start-write commands return a zero data word
    `ADIM_ASSERT_NXT(a_zero_data, aclk, aresetn, quiet_beat, data_zero, "beat carries data")

    // A stalled result beat holds
    `ADIM_ASSERT_NXT(a_out_hold, aclk, aresetn, out_stall, $stable(out_beat), "stalled beat changed")

endmodule

bind ad_input_multiplexer adim_checker u_adim_checker (.*);
